FILE: src/csra_pkg.sv
// ----------------------------------------------------------------------------
// csra_pkg: shared types and constants of the sparse row accumulator
// Request structs of the input and result channels, the internal operation
// codes and the entry format of the queue between the front and back parts.
// ----------------------------------------------------------------------------
package csra_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int VectorDepthDef = 4096;
  localparam int RowBitsDef     = 16;

  // Depth of the queue between the front and back parts.
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  // Function codes of an input request.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_MAC   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Reset value of the row limit register.
  localparam logic [16:0] NUM_ROWS_RESET = 17'h10000;

  // Saturation limits of the 48-bit row sum.
  localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        row;
    logic [11:0]        col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_row;
    logic signed [47:0] sum;
  } out_item_t;

  // Classified operation carried from the front to the back part.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MAC,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        row;
    logic [11:0]        col;
    logic               col_ok;
    logic signed [31:0] value;
  } q_item_t;

endpackage

FILE: src/csra_front.sv
// ----------------------------------------------------------------------------
// csra_front: request intake and classification
// Decodes the function code, masks the row to its active width, checks the
// column against the vector store depth and drops requests that do nothing.
// ----------------------------------------------------------------------------
module csra_front import csra_pkg::*; #(
  parameter int VECTOR_DEPTH = VectorDepthDef,
  parameter int ROW_BITS     = RowBitsDef
) (
  input  logic     in_valid,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     in_stall,
  output logic     q_push,
  output q_item_t  q_item
);

  logic [15:0] row_m;
  logic        col_ok;
  logic        keep;

  // Keep only the row bits that are in use.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      row_m[i] = (i < ROW_BITS) ? in_data.row[i] : 1'b0;
    end
  end

  assign col_ok = (32'(in_data.col) < VECTOR_DEPTH);

  // Classify the request; unused codes and loads beyond the store vanish.
  always_comb begin
    q_item.row    = row_m;
    q_item.col    = in_data.col;
    q_item.col_ok = col_ok;
    q_item.value  = in_data.value;
    q_item.op     = OP_MAC;
    keep          = 1'b0;
    case (in_data.func)
      FUNC_LOAD: begin
        q_item.op = OP_LOAD;
        keep      = col_ok;
      end
      FUNC_MAC: begin
        q_item.op = OP_MAC;
        keep      = 1'b1;
      end
      FUNC_FLUSH: begin
        q_item.op = OP_FLUSH;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

FILE: src/csra_fifo.sv
// ----------------------------------------------------------------------------
// csra_fifo: short queue between the front and back parts
// Holds classified requests so that intake and execution stall on their own.
// ----------------------------------------------------------------------------
module csra_fifo import csra_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    nempty,
  output q_item_t pop_item
);

  q_item_t            store_r [QueueDepth];
  logic [QueueAw-1:0] wptr_r;
  logic [QueueAw-1:0] rptr_r;
  logic [QueueAw:0]   count_r;

  assign full     = (count_r == (QueueAw+1)'(QueueDepth));
  assign nempty   = (count_r != '0);
  assign pop_item = store_r[rptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/csra_back.sv
// ----------------------------------------------------------------------------
// csra_back: vector store, multiplier and row accumulator
// Stage A reads or writes the vector store, stage B multiplies, and stage C
// accumulates into the open row and presents closed rows in the output register.
// ----------------------------------------------------------------------------
module csra_back import csra_pkg::*; #(
  parameter int VECTOR_DEPTH = VectorDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nempty,
  input  q_item_t     q_item,
  output logic        q_pop,
  input  logic [16:0] num_rows,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic [31:0]        vstore [VECTOR_DEPTH];
  logic [31:0]        col_ext;
  logic [AW-1:0]      addr;
  logic               adv;

  logic               a_valid_r;
  op_t                a_op_r;
  logic [15:0]        a_row_r;
  logic               a_col_ok_r;
  logic signed [31:0] a_value_r;
  logic [31:0]        rdata_r;
  logic signed [31:0] vec_x;

  logic               b_valid_r;
  op_t                b_op_r;
  logic [15:0]        b_row_r;
  logic signed [63:0] b_prod_r;

  logic [15:0]        open_row_r;
  logic               open_r;
  logic signed [47:0] sum_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [15:0]        open_row_nxt;
  logic               open_nxt;
  logic signed [47:0] sum_nxt;
  logic               emit;
  logic signed [47:0] base;
  logic signed [48:0] acc;
  logic               row_live;

  // The whole back part advances unless a result is held by the receiver.
  assign adv   = !(out_valid_r && out_stall);
  assign q_pop = adv && q_nempty;

  assign col_ext = {20'd0, q_item.col};
  assign addr    = col_ext[AW-1:0];

  // Stage A: vector store access, loads and reads in request order.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_item.op == OP_LOAD) begin
        vstore[addr] <= q_item.value;
      end
      rdata_r <= vstore[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_op_r     <= q_item.op;
      a_row_r    <= q_item.row;
      a_col_ok_r <= q_item.col_ok;
      a_value_r  <= q_item.value;
    end
  end

  // Stage B: full product of matrix value and vector entry.
  assign vec_x = a_col_ok_r ? signed'(rdata_r) : 32'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op_r   <= a_op_r;
      b_row_r  <= a_row_r;
      b_prod_r <= a_value_r * vec_x;
    end
  end

  // Stage C: close the open row when needed, then accumulate with saturation.
  assign row_live = open_r && ({1'b0, open_row_r} < num_rows);

  always_comb begin
    open_row_nxt = open_row_r;
    open_nxt     = open_r;
    sum_nxt      = sum_r;
    emit         = 1'b0;
    base         = sum_r;
    acc          = '0;
    if (b_valid_r) begin
      case (b_op_r)
        OP_MAC: begin
          if (open_r && (b_row_r != open_row_r)) begin
            emit = row_live;
            base = '0;
          end else if (!open_r) begin
            base = '0;
          end
          // Dropping the low 16 product bits floors the Q32.32 product.
          acc = {base[47], base} + {b_prod_r[63], b_prod_r[63:16]};
          if (acc[48] != acc[47]) begin
            sum_nxt = acc[48] ? SUM_MIN : SUM_MAX;
          end else begin
            sum_nxt = acc[47:0];
          end
          open_row_nxt = b_row_r;
          open_nxt     = 1'b1;
        end
        OP_FLUSH: begin
          emit     = row_live;
          open_nxt = 1'b0;
          sum_nxt  = '0;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_row_r  <= '0;
      open_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      open_row_r  <= open_row_nxt;
      open_r      <= open_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= emit;
    end
  end

  // Result register holds the closed row and its sum.
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_data_r.out_row <= open_row_r;
      out_data_r.sum     <= sum_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/coo_sparse_row_accumulator_core.sv
// ----------------------------------------------------------------------------
// coo_sparse_row_accumulator_core: sparse matrix by dense vector, row by row
// Accepts one request per cycle while the queue is not full. A row closed by
// a request reaches out_valid through the queue, store read, multiply and
// accumulate steps. Throughput is bound by the single accumulate loop.
// Synchronous reset clears control state and the open row and sets the row
// limit to 65536; the vector store is undefined until loaded.
// ----------------------------------------------------------------------------
module coo_sparse_row_accumulator_core import csra_pkg::*; #(
  parameter int VECTOR_DEPTH = VectorDepthDef,
  parameter int ROW_BITS     = RowBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  logic        q_push;
  q_item_t     q_push_item;
  logic        q_full;
  logic        q_pop;
  logic        q_nempty;
  q_item_t     q_pop_item;
  logic [16:0] num_rows_r;

  // Row limit register, writable at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= NUM_ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_rows_r <= cfg_data;
    end
  end

  csra_front #(
    .VECTOR_DEPTH(VECTOR_DEPTH),
    .ROW_BITS    (ROW_BITS)
  ) u_front (
    .in_valid(in_valid),
    .in_data (in_data),
    .q_full  (q_full),
    .in_stall(in_stall),
    .q_push  (q_push),
    .q_item  (q_push_item)
  );

  csra_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_push_item),
    .full     (q_full),
    .pop      (q_pop),
    .nempty   (q_nempty),
    .pop_item (q_pop_item)
  );

  csra_back #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_nempty (q_nempty),
    .q_item   (q_pop_item),
    .q_pop    (q_pop),
    .num_rows (num_rows_r),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

FILE: sim/tb_coo_sparse_row_accumulator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coo_sparse_row_accumulator_core: self-checking bench of the row accumulator
// Loads vector entries and streams nonzeros, flushes and unused codes through
// the core under bursty requests and a stalling receiver, across several row
// limits. A scoreboard predicts every closed row and its saturated sum and
// compares each result request with the oldest expected row.
// ----------------------------------------------------------------------------
module tb_coo_sparse_row_accumulator_core;
  import csra_pkg::*;

  localparam int          VecDepth    = VectorDepthDef;
  localparam logic [1:0]  FuncUnused  = 2'd3;
  localparam longint      SumHigh     = 64'sd140737488355327;
  localparam longint      SumLow      = -SumHigh - 1;
  localparam int          QuietLimit  = 2000;
  localparam int          SettleWait  = 6;
  localparam int          PhaseItems  = 100;

  // Predicts the closed rows and checks them against the result requests.
  class row_sum_scoreboard;
    logic signed [31:0] vec_entry [VecDepth];
    logic [15:0]        open_row;
    bit                 row_open;
    longint             row_acc;
    logic [16:0]        row_limit;
    out_item_t          expected_rows [$];
    int                 err_count;

    function new();
      open_row  = '0;
      row_open  = 1'b0;
      row_acc   = 0;
      row_limit = NUM_ROWS_RESET;
      err_count = 0;
    endfunction

    function void set_limit(logic [16:0] lim);
      row_limit = lim;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    // Closing a row emits it only when it lies below the row limit.
    function void close_open_row();
      out_item_t row_done;
      if (row_open && {1'b0, open_row} < row_limit) begin
        row_done.out_row = open_row;
        row_done.sum     = row_acc[47:0];
        expected_rows.push_back(row_done);
      end
      row_open = 1'b0;
      row_acc  = 0;
    endfunction

    function void note_request(in_item_t req);
      longint prod;
      longint acc;
      case (req.func)
        FUNC_LOAD: vec_entry[req.col] = req.value;
        FUNC_FLUSH: close_open_row();
        FUNC_MAC: begin
          if (row_open && req.row != open_row) close_open_row();
          if (!row_open) begin
            open_row = req.row;
            row_open = 1'b1;
            row_acc  = 0;
          end
          // Q32.32 product, floored to Q32.16, then a clamped accumulate.
          prod = longint'(req.value) * longint'(vec_entry[req.col]);
          acc  = row_acc + (prod >>> 16);
          if (acc > SumHigh) acc = SumHigh;
          if (acc < SumLow) acc = SumLow;
          row_acc = acc;
        end
        default: ;
      endcase
    endfunction

    function void check_row(out_item_t got);
      out_item_t want;
      if (expected_rows.size() == 0) begin
        $error("unexpected row result: out_row %0d sum %0d", got.out_row, got.sum);
        err_count++;
        return;
      end
      want = expected_rows.pop_front();
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
        err_count++;
      end
      if (got.sum !== want.sum) begin
        $error("sum: expected %0d, actual %0d", want.sum, got.sum);
        err_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;

  row_sum_scoreboard sb = new();

  // Stimulus state: which vector entries hold data, and the current row.
  bit          col_loaded [VecDepth];
  int          loaded_cols [$];
  logic [15:0] cur_row;
  int          burst_left;
  int          quiet_cycles;

  coo_sparse_row_accumulator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result monitor: a result request is taken when valid and not stalled.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_row(out_data);
  end

  // Watchdog: ends the run after too many cycles with no request moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_coo_sparse_row_accumulator_core: done, errors");
        $finish;
      end
    end
  end

  // Receiver stalls in stretches: none, random, mostly stalled, or solid.
  initial begin : stall_pattern
    int mode;
    int len;
    int k;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 40);
      for (k = 0; k < len; k++) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (k % 4) != 0;
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] f, logic [15:0] r, logic [11:0] c,
                                         logic [31:0] v);
    in_item_t it;
    it.func  = f;
    it.row   = r;
    it.col   = c;
    it.value = v;
    return it;
  endfunction

  // Mostly small fixed-point values, sometimes the full 32-bit range.
  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 9) < 6) return 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
    return $urandom;
  endfunction

  // Well-formed row streams with loads and flushes, plus jumps and unused codes.
  function automatic in_item_t next_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return make_item(FUNC_LOAD, 16'($urandom), 12'($urandom), rand_value());
    if (pick < 15) return make_item(FUNC_FLUSH, 16'($urandom), 12'($urandom), $urandom);
    if (pick < 18) return make_item(FuncUnused, 16'($urandom), 12'($urandom), $urandom);
    if (pick < 23) cur_row = 16'($urandom_range(0, 65535));
    else if (pick < 45) cur_row = cur_row + 16'($urandom_range(1, 3));
    return make_item(FUNC_MAC, cur_row,
                     12'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]),
                     rand_value());
  endfunction

  // Offers one request, waits for it to be taken, then maybe opens a gap.
  task automatic push_request(in_item_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    if (req.func == FUNC_LOAD && !col_loaded[req.col]) begin
      col_loaded[req.col] = 1'b1;
      loaded_cols.push_back(int'(req.col));
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
    end
  endtask

  // Waits until every expected row has arrived and the pipeline is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_row_limit(logic [16:0] lim);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_limit(lim);
  endtask

  // Extremes of the values, saturation both ways, floor rounding, row changes.
  task automatic run_directed();
    push_request(make_item(FUNC_LOAD, 16'd0, 12'd0, 32'h7FFF_FFFF));
    push_request(make_item(FUNC_LOAD, 16'd0, 12'd4095, 32'h8000_0000));
    push_request(make_item(FUNC_LOAD, 16'd0, 12'd1, 32'h0001_0000));
    push_request(make_item(FUNC_LOAD, 16'd0, 12'd2, 32'h0000_0001));
    push_request(make_item(FuncUnused, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF));
    push_request(make_item(FUNC_FLUSH, 16'd0, 12'd0, 32'd0));
    repeat (3) push_request(make_item(FUNC_MAC, 16'd0, 12'd0, 32'h7FFF_FFFF));
    repeat (3) push_request(make_item(FUNC_MAC, 16'd1, 12'd4095, 32'h7FFF_FFFF));
    push_request(make_item(FUNC_MAC, 16'd2, 12'd2, 32'hFFFF_FFFF));
    push_request(make_item(FUNC_MAC, 16'd2, 12'd4095, 32'h8000_0000));
    push_request(make_item(FUNC_MAC, 16'hFFFF, 12'd1, 32'h1234_5678));
    // A lower row closes the open one, and a row seen before starts afresh.
    push_request(make_item(FUNC_MAC, 16'd3, 12'd1, 32'hFFFF_0000));
    push_request(make_item(FUNC_MAC, 16'hFFFF, 12'd2, 32'd5));
    push_request(make_item(FUNC_FLUSH, 16'd0, 12'd0, 32'd0));
    push_request(make_item(FUNC_FLUSH, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF));
    push_request(make_item(FUNC_MAC, 16'd9, 12'd0, 32'h8000_0000));
    push_request(make_item(FUNC_FLUSH, 16'd0, 12'd0, 32'd0));
  endtask

  initial begin : main
    logic [16:0] limits [8];
    int          p;
    int          sent;
    in_item_t    req;

    in_valid   <= 1'b0;
    in_data    <= '0;
    out_stall  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    cur_row    = '0;
    burst_left = 1;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();

    // Row limits: none emitted, only row zero, above the row range, reset
    // value, small random limits, 300, and the largest limit below the reset.
    limits = '{17'd0, 17'd1, 17'h1FFFF, NUM_ROWS_RESET,
               17'($urandom_range(1, 64)), 17'($urandom_range(1, 64)), 17'd300, 17'hFFFF};
    for (p = 0; p < 8; p++) begin
      write_row_limit(limits[p]);
      cur_row = '0;
      sent = 0;
      while (sent < PhaseItems) begin
        req = next_item();
        push_request(req);
        if (req.func != FuncUnused) sent++;
      end
      push_request(make_item(FUNC_FLUSH, 16'd0, 12'd0, 32'd0));
      drain();
    end

    if (sb.err_count == 0 && sb.pending() == 0)
      $display("tb_coo_sparse_row_accumulator_core: done, clean");
    else
      $display("tb_coo_sparse_row_accumulator_core: done, errors");
    $finish;
  end

endmodule
